[hw/rtl/mlqs_pkg.sv]
// Shared types and constants for the multilevel queue scheduler.
package mlqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int KIND_W    = 2;
  localparam int TAG_W     = 8;
  localparam int LVL_W     = 2;
  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 16;
  localparam int CLK_W     = 20;
  localparam int QUANT_W   = 8;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(4);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_NEXT  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_IDLE = 2'd0,
    LVL_RR   = 2'd1,
    LVL_PRIO = 2'd2,
    LVL_FCFS = 2'd3
  } level_t;

  // One job table entry, including its remaining burst.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    level_t             level;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  // Control from the sequencer to the candidate evaluator.
  typedef struct packed {
    logic             start;
    logic             sample;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rr;
  } eval_ctrl_t;

  // Winners of one table scan, one per level.
  typedef struct packed {
    logic             l1_found;
    logic [IDX_W-1:0] l1_idx;
    logic             l2_found;
    logic [IDX_W-1:0] l2_idx;
    logic             l3_found;
    logic [IDX_W-1:0] l3_idx;
  } pick_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SERVE,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/multilevel_queue_scheduler_unit.sv]
// Top level of the multilevel queue scheduler: sequencer, clock and output register.
//
//   Channel  Direction  Handshake          Contents
//   in_      slave      tvalid/tready      tuser: kind; tdata: job fields
//   out_     master     tvalid/tready      tuser: all_done; tdata: slice fields
//   cfg_     write      wr_en (no wait)    wr_data: quantum
//
// A load, clear or unused kind is handled in the idle state. A slice request
// reads the job table memory one entry per cycle through its single read
// port while the evaluator updates the per-level winners; after a drain
// state, the decide state picks the winner and the serve state updates it.
// With an empty table a request goes straight to the decide state. The
// result waits in the output register; a new word is accepted while it
// waits, but a slice is only committed once the output register is free.
// Reset (rst_n low, synchronous) empties the table, zeroes the clock and
// the round robin pointer and sets the quantum to 4.
module multilevel_queue_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] job_tag, [9:8] job_level, [17:10] job_priority, [33:18] burst_length
  input  logic [39:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] served_level, [9:2] served_tag, [17:10] served_priority,
  // [37:18] slice_start, [57:38] slice_end
  output logic [63:0] out_tdata,
  // [0] all_done
  output logic        out_tuser,

  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  // Sequencer state and bookkeeping.
  mlqs_pkg::state_t                state_r, state_nxt;
  logic [mlqs_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [mlqs_pkg::CLK_W-1:0]      clock_r, clock_nxt;
  logic [mlqs_pkg::IDX_W-1:0]      rr_r, rr_nxt;
  logic [mlqs_pkg::QUANT_W-1:0]    quantum_r;
  logic [mlqs_pkg::IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                            rd_valid_r;
  logic [mlqs_pkg::IDX_W-1:0]      rd_idx_r;
  logic [mlqs_pkg::IDX_W-1:0]      sel_idx_r, sel_idx_nxt;
  logic                            sel_rr_r, sel_rr_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  mlqs_pkg::level_t                out_level_r, out_level_nxt;
  logic [mlqs_pkg::TAG_W-1:0]      out_tag_r, out_tag_nxt;
  logic [mlqs_pkg::PRIO_W-1:0]     out_prio_r, out_prio_nxt;
  logic [mlqs_pkg::CLK_W-1:0]      out_start_r, out_start_nxt;
  logic [mlqs_pkg::CLK_W-1:0]      out_end_r, out_end_nxt;
  logic                            out_done_r, out_done_nxt;

  // Input word fields.
  mlqs_pkg::kind_t                 in_kind;
  mlqs_pkg::entry_t                in_entry;
  logic                            in_accept;

  // Table and evaluator connections.
  logic                            tbl_wr_en;
  logic [mlqs_pkg::IDX_W-1:0]      tbl_wr_addr;
  mlqs_pkg::entry_t                tbl_wr_data;
  logic [mlqs_pkg::IDX_W-1:0]      tbl_rd_addr;
  mlqs_pkg::entry_t                tbl_rd_data;
  mlqs_pkg::eval_ctrl_t            ev_ctrl;
  mlqs_pkg::pick_t                 pick;

  // Helpers.
  logic                            slot_free;
  logic                            any_found;
  logic [mlqs_pkg::IDX_W-1:0]      pick_idx;
  logic                            rr_wrap;
  logic [mlqs_pkg::CNT_W-1:0]      scan_last;
  logic [mlqs_pkg::BURST_W-1:0]    quant_eff;
  logic [mlqs_pkg::BURST_W-1:0]    amount;
  logic [mlqs_pkg::CNT_W-1:0]      sel_plus;
  logic                            serve_go;

  assign in_kind            = mlqs_pkg::kind_t'(in_tuser);
  assign in_entry.tag       = in_tdata[7:0];
  assign in_entry.level     = mlqs_pkg::level_t'(in_tdata[9:8]);
  assign in_entry.prio      = in_tdata[17:10];
  assign in_entry.remaining = in_tdata[33:18];

  assign in_tready = (state_r == mlqs_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // The round robin pointer falls back to zero once it points past the table.
  assign rr_wrap   = ({1'b0, rr_r} >= count_r);
  assign scan_last = count_r - mlqs_pkg::CNT_W'(1);

  // Level one wins over level two, which wins over level three.
  assign any_found = pick.l1_found || pick.l2_found || pick.l3_found;
  assign pick_idx  = pick.l1_found ? pick.l1_idx :
                     pick.l2_found ? pick.l2_idx : pick.l3_idx;

  // Slice length: for round robin the quantum (zero acts as one) capped by the remaining burst, else the whole burst.
  assign quant_eff = (quantum_r == '0) ? mlqs_pkg::BURST_W'(1)
                                       : mlqs_pkg::BURST_W'(quantum_r);
  assign amount    = (sel_rr_r && (tbl_rd_data.remaining > quant_eff)) ? quant_eff
                                                                      : tbl_rd_data.remaining;
  assign sel_plus  = mlqs_pkg::CNT_W'(sel_idx_r) + mlqs_pkg::CNT_W'(1);
  // The serve commit is the only point where the table and the clock move together.
  assign serve_go  = (state_r == mlqs_pkg::ST_SERVE) && slot_free;

  mlqs_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  mlqs_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ev_ctrl),
    .entry (tbl_rd_data),
    .pick  (pick)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlqs_pkg::ST_IDLE: begin
        if (in_accept && (in_kind == mlqs_pkg::KIND_NEXT)) begin
          state_nxt = (count_r == '0) ? mlqs_pkg::ST_DECIDE : mlqs_pkg::ST_SCAN;
        end
      end
      mlqs_pkg::ST_SCAN: begin
        if (mlqs_pkg::CNT_W'(scan_idx_r) == scan_last) begin
          state_nxt = mlqs_pkg::ST_DRAIN;
        end
      end
      mlqs_pkg::ST_DRAIN: begin
        state_nxt = mlqs_pkg::ST_DECIDE;
      end
      mlqs_pkg::ST_DECIDE: begin
        state_nxt = any_found ? mlqs_pkg::ST_SERVE : mlqs_pkg::ST_DONE;
      end
      mlqs_pkg::ST_SERVE: begin
        if (slot_free) begin
          state_nxt = mlqs_pkg::ST_IDLE;
        end
      end
      mlqs_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = mlqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mlqs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs to the table and the evaluator.
  always_comb begin
    tbl_wr_en           = 1'b0;
    tbl_wr_addr         = sel_idx_r;
    tbl_wr_data         = tbl_rd_data;
    tbl_wr_data.remaining = tbl_rd_data.remaining - amount;
    tbl_rd_addr         = sel_idx_r;
    ev_ctrl.start       = 1'b0;
    ev_ctrl.sample      = rd_valid_r;
    ev_ctrl.idx         = rd_idx_r;
    ev_ctrl.rr          = rr_r;
    case (state_r)
      mlqs_pkg::ST_IDLE: begin
        ev_ctrl.start = in_accept && (in_kind == mlqs_pkg::KIND_NEXT);
        if (in_accept && (in_kind == mlqs_pkg::KIND_LOAD)
            && (count_r < mlqs_pkg::CNT_W'(mlqs_pkg::MAX_PROCS))) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = mlqs_pkg::IDX_W'(count_r);
          tbl_wr_data = in_entry;
        end
      end
      mlqs_pkg::ST_SCAN: begin
        tbl_rd_addr = scan_idx_r;
      end
      mlqs_pkg::ST_DECIDE: begin
        tbl_rd_addr = pick_idx;
      end
      mlqs_pkg::ST_SERVE: begin
        tbl_wr_en = serve_go;
      end
      default: begin
        tbl_wr_en = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    count_nxt     = count_r;
    clock_nxt     = clock_r;
    rr_nxt        = rr_r;
    scan_idx_nxt  = scan_idx_r;
    sel_idx_nxt   = sel_idx_r;
    sel_rr_nxt    = sel_rr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_level_nxt = out_level_r;
    out_tag_nxt   = out_tag_r;
    out_prio_nxt  = out_prio_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_done_nxt  = out_done_r;

    case (state_r)
      mlqs_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            mlqs_pkg::KIND_LOAD: begin
              if (count_r < mlqs_pkg::CNT_W'(mlqs_pkg::MAX_PROCS)) begin
                count_nxt = count_r + mlqs_pkg::CNT_W'(1);
              end
            end
            mlqs_pkg::KIND_NEXT: begin
              scan_idx_nxt = '0;
              if (rr_wrap) begin
                rr_nxt = '0;
              end
            end
            mlqs_pkg::KIND_CLEAR: begin
              count_nxt = '0;
              clock_nxt = '0;
              rr_nxt    = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
        end
      end
      mlqs_pkg::ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + mlqs_pkg::IDX_W'(1);
      end
      mlqs_pkg::ST_DECIDE: begin
        sel_idx_nxt = pick_idx;
        sel_rr_nxt  = pick.l1_found;
      end
      mlqs_pkg::ST_SERVE: begin
        if (slot_free) begin
          clock_nxt     = clock_r + mlqs_pkg::CLK_W'(amount);
          out_valid_nxt = 1'b1;
          out_level_nxt = tbl_rd_data.level;
          out_tag_nxt   = tbl_rd_data.tag;
          out_prio_nxt  = tbl_rd_data.prio;
          out_start_nxt = clock_r;
          out_end_nxt   = clock_r + mlqs_pkg::CLK_W'(amount);
          out_done_nxt  = 1'b0;
          if (sel_rr_r) begin
            rr_nxt = (sel_plus >= count_r) ? '0 : mlqs_pkg::IDX_W'(sel_plus);
          end
        end
      end
      mlqs_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = mlqs_pkg::LVL_IDLE;
          out_tag_nxt   = '0;
          out_prio_nxt  = '0;
          out_start_nxt = clock_r;
          out_end_nxt   = clock_r;
          out_done_nxt  = 1'b1;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlqs_pkg::ST_IDLE;
      count_r     <= '0;
      clock_r     <= '0;
      rr_r        <= '0;
      quantum_r   <= mlqs_pkg::QUANT_RESET;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clock_r     <= clock_nxt;
      rr_r        <= rr_nxt;
      rd_valid_r  <= (state_r == mlqs_pkg::ST_SCAN);
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= scan_idx_r;
    sel_idx_r   <= sel_idx_nxt;
    sel_rr_r    <= sel_rr_nxt;
    out_level_r <= out_level_nxt;
    out_tag_r   <= out_tag_nxt;
    out_prio_r  <= out_prio_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_done_r;
  assign out_tdata  = {6'b0, out_end_r, out_start_r, out_prio_r, out_tag_r, out_level_r};

endmodule

[hw/rtl/mlqs_table.sv]
// Job table memory: one write port, one registered read port.
module mlqs_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mlqs_pkg::IDX_W-1:0]  wr_addr,
  input  mlqs_pkg::entry_t            wr_data,
  input  logic [mlqs_pkg::IDX_W-1:0]  rd_addr,
  output mlqs_pkg::entry_t            rd_data
);

  mlqs_pkg::entry_t mem [0:mlqs_pkg::MAX_PROCS-1];
  mlqs_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/mlqs_eval.sv]
// Candidate evaluator: looks at one table entry per cycle and keeps the winner of each level.
module mlqs_eval (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mlqs_pkg::eval_ctrl_t   ctrl,
  input  mlqs_pkg::entry_t       entry,
  output mlqs_pkg::pick_t        pick
);

  // Round robin keeps two candidates: first at or after the pointer, and first overall.
  logic                         l1a_found_r, l1a_found_nxt;
  logic [mlqs_pkg::IDX_W-1:0]   l1a_idx_r, l1a_idx_nxt;
  logic                         l1b_found_r, l1b_found_nxt;
  logic [mlqs_pkg::IDX_W-1:0]   l1b_idx_r, l1b_idx_nxt;
  logic                         l2_found_r, l2_found_nxt;
  logic [mlqs_pkg::IDX_W-1:0]   l2_idx_r, l2_idx_nxt;
  logic [mlqs_pkg::PRIO_W-1:0]  l2_prio_r, l2_prio_nxt;
  logic                         l3_found_r, l3_found_nxt;
  logic [mlqs_pkg::IDX_W-1:0]   l3_idx_r, l3_idx_nxt;

  logic live;
  logic pend1;
  logic pend2;
  logic pend3;

  always_comb begin
    live  = (entry.remaining != '0);
    pend1 = live && (entry.level == mlqs_pkg::LVL_RR);
    pend2 = live && (entry.level == mlqs_pkg::LVL_PRIO);
    pend3 = live && (entry.level == mlqs_pkg::LVL_FCFS);

    l1a_found_nxt = l1a_found_r;
    l1a_idx_nxt   = l1a_idx_r;
    l1b_found_nxt = l1b_found_r;
    l1b_idx_nxt   = l1b_idx_r;
    l2_found_nxt  = l2_found_r;
    l2_idx_nxt    = l2_idx_r;
    l2_prio_nxt   = l2_prio_r;
    l3_found_nxt  = l3_found_r;
    l3_idx_nxt    = l3_idx_r;

    if (ctrl.start) begin
      l1a_found_nxt = 1'b0;
      l1b_found_nxt = 1'b0;
      l2_found_nxt  = 1'b0;
      l3_found_nxt  = 1'b0;
    end else if (ctrl.sample) begin
      if (pend1 && !l1a_found_r && (ctrl.idx >= ctrl.rr)) begin
        l1a_found_nxt = 1'b1;
        l1a_idx_nxt   = ctrl.idx;
      end
      if (pend1 && !l1b_found_r) begin
        l1b_found_nxt = 1'b1;
        l1b_idx_nxt   = ctrl.idx;
      end
      // Strict less-than keeps the lower index on a priority tie.
      if (pend2 && (!l2_found_r || (entry.prio < l2_prio_r))) begin
        l2_found_nxt = 1'b1;
        l2_idx_nxt   = ctrl.idx;
        l2_prio_nxt  = entry.prio;
      end
      if (pend3 && !l3_found_r) begin
        l3_found_nxt = 1'b1;
        l3_idx_nxt   = ctrl.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1a_found_r <= 1'b0;
      l1b_found_r <= 1'b0;
      l2_found_r  <= 1'b0;
      l3_found_r  <= 1'b0;
    end else begin
      l1a_found_r <= l1a_found_nxt;
      l1b_found_r <= l1b_found_nxt;
      l2_found_r  <= l2_found_nxt;
      l3_found_r  <= l3_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l1a_idx_r <= l1a_idx_nxt;
    l1b_idx_r <= l1b_idx_nxt;
    l2_idx_r  <= l2_idx_nxt;
    l2_prio_r <= l2_prio_nxt;
    l3_idx_r  <= l3_idx_nxt;
  end

  always_comb begin
    pick.l1_found = l1a_found_r || l1b_found_r;
    pick.l1_idx   = l1a_found_r ? l1a_idx_r : l1b_idx_r;
    pick.l2_found = l2_found_r;
    pick.l2_idx   = l2_idx_r;
    pick.l3_found = l3_found_r;
    pick.l3_idx   = l3_idx_r;
  end

endmodule

[tb/mlqs_slice_checker.sv]
// Slice predictor and result comparison for the multilevel queue scheduler testbench.
`timescale 1ns / 100ps
module mlqs_slice_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [7:0] job_tag, [9:8] job_level, [17:10] job_priority, [33:18] burst_length
  input  logic [39:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] served_level, [9:2] served_tag, [17:10] served_priority,
  // [37:18] slice_start, [57:38] slice_end
  input  logic [63:0] out_tdata,
  // [0] all_done
  input  logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int unsigned fail_count,
  output int unsigned open_slices
);

  typedef struct packed {
    mlqs_pkg::level_t                 level;
    logic [mlqs_pkg::TAG_W-1:0]       tag;
    logic [mlqs_pkg::PRIO_W-1:0]      prio;
    logic [mlqs_pkg::CLK_W-1:0]       slice_start;
    logic [mlqs_pkg::CLK_W-1:0]       slice_end;
    logic                             all_done;
  } slice_t;

  slice_t                           expected_slices[$];
  int unsigned                      mismatches = 0;
  logic [mlqs_pkg::QUANT_W-1:0]     quantum;
  int unsigned                      job_count;
  logic [mlqs_pkg::TAG_W-1:0]       job_tag   [mlqs_pkg::MAX_PROCS];
  mlqs_pkg::level_t                 job_level [mlqs_pkg::MAX_PROCS];
  logic [mlqs_pkg::PRIO_W-1:0]      job_prio  [mlqs_pkg::MAX_PROCS];
  logic [mlqs_pkg::BURST_W-1:0]     job_left  [mlqs_pkg::MAX_PROCS];
  logic [mlqs_pkg::CLK_W-1:0]       sched_clock;
  int unsigned                      rr_next;

  task automatic serve_job(input int unsigned idx,
                           input logic [mlqs_pkg::BURST_W-1:0] amount,
                           output slice_t s);
    s.level       = job_level[idx];
    s.tag         = job_tag[idx];
    s.prio        = job_prio[idx];
    s.slice_start = sched_clock;
    s.slice_end   = sched_clock + mlqs_pkg::CLK_W'(amount);
    s.all_done    = 1'b0;
    job_left[idx] = job_left[idx] - amount;
    sched_clock   = s.slice_end;
  endtask

  task automatic predict_slice(output slice_t s);
    int unsigned                  idx;
    int unsigned                  best;
    bit                           found;
    logic [mlqs_pkg::BURST_W-1:0] q;
    q = (quantum == '0) ? mlqs_pkg::BURST_W'(1) : mlqs_pkg::BURST_W'(quantum);
    // Round robin level: scan cyclically from the pointer.
    if (rr_next >= job_count) rr_next = 0;
    for (int unsigned k = 0; k < job_count; k++) begin
      idx = rr_next + k;
      if (idx >= job_count) idx -= job_count;
      if (job_level[idx] == mlqs_pkg::LVL_RR && job_left[idx] != '0) begin
        rr_next = (idx + 1 >= job_count) ? 0 : idx + 1;
        serve_job(idx, (job_left[idx] < q) ? job_left[idx] : q, s);
        return;
      end
    end
    // Priority level: smallest value, lower index on a tie.
    found = 1'b0;
    best  = 0;
    for (int unsigned i = 0; i < job_count; i++) begin
      if (job_level[i] == mlqs_pkg::LVL_PRIO && job_left[i] != '0 &&
          (!found || job_prio[i] < job_prio[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      serve_job(best, job_left[best], s);
      return;
    end
    // First come first served level.
    for (int unsigned i = 0; i < job_count; i++) begin
      if (job_level[i] == mlqs_pkg::LVL_FCFS && job_left[i] != '0) begin
        serve_job(i, job_left[i], s);
        return;
      end
    end
    s = '{mlqs_pkg::LVL_IDLE, '0, '0, sched_clock, sched_clock, 1'b1};
  endtask

  always @(posedge clk) begin
    slice_t got;
    slice_t want;
    if (!rst_n) begin
      quantum     = mlqs_pkg::QUANT_RESET;
      job_count   = 0;
      sched_clock = '0;
      rr_next     = 0;
      expected_slices.delete();
    end else begin
      if (cfg_wr_en) quantum = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        case (mlqs_pkg::kind_t'(in_tuser))
          mlqs_pkg::KIND_LOAD: begin
            if (job_count < mlqs_pkg::MAX_PROCS) begin
              job_tag[job_count]   = in_tdata[7:0];
              job_level[job_count] = mlqs_pkg::level_t'(in_tdata[9:8]);
              job_prio[job_count]  = in_tdata[17:10];
              job_left[job_count]  = in_tdata[33:18];
              job_count++;
            end
          end
          mlqs_pkg::KIND_NEXT: begin
            predict_slice(want);
            expected_slices.push_back(want);
          end
          mlqs_pkg::KIND_CLEAR: begin
            job_count   = 0;
            sched_clock = '0;
            rr_next     = 0;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.level       = mlqs_pkg::level_t'(out_tdata[1:0]);
        got.tag         = out_tdata[9:2];
        got.prio        = out_tdata[17:10];
        got.slice_start = out_tdata[37:18];
        got.slice_end   = out_tdata[57:38];
        got.all_done    = out_tuser;
        if (expected_slices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: result word with nothing expected: lvl %0d tag %0d", got.level,
                     got.tag);
        end else begin
          want = expected_slices.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: mismatch at %0t", $realtime);
              $display("  expected lvl %0d tag %0d prio %0d start %0d end %0d done %0d",
                       want.level, want.tag, want.prio, want.slice_start, want.slice_end,
                       want.all_done);
              $display("  got      lvl %0d tag %0d prio %0d start %0d end %0d done %0d",
                       got.level, got.tag, got.prio, got.slice_start, got.slice_end,
                       got.all_done);
            end
          end
        end
      end
    end
    fail_count  <= mismatches;
    open_slices <= expected_slices.size();
  end

endmodule

[tb/testbench.sv]
// Testbench top for the multilevel queue scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  // This limit leaves a wide margin above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // Time to wait before touching the quantum or ending the run; it is longer
  // than a slice request on a full table takes.
  localparam int unsigned SETTLE_CYCLES = 2 * mlqs_pkg::MAX_PROCS;
  localparam int unsigned PHASE_WORDS   = 130;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASES        = 5;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  int unsigned fail_count;
  int unsigned open_slices;

  // Stimulus bookkeeping. The slice estimate only shapes how many requests an
  // episode sends; it plays no part in checking.
  int unsigned                  words_sent   = 0;
  int unsigned                  slices_left  = 0;
  logic [mlqs_pkg::QUANT_W-1:0] cur_quantum  = mlqs_pkg::QUANT_RESET;
  int unsigned                  cycle_count  = 0;

  // Flags from the stimulus process to the receiver process.
  logic        quiet        = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_taken   = 1'b0;
  int unsigned stall_left   = 0;

  multilevel_queue_scheduler_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mlqs_slice_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .open_slices (open_slices)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver. Short random stalls, one long hold-off while the sender keeps
  // offering requests so that the result register fills and the block stops
  // accepting input, and no stalls at all once quiet is set.
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offers one word and returns at the edge where it is accepted. A random
  // gap may come first unless the run is in its quiet part.
  // The valid stays high on return so that back-to-back words need no toggle.
  task automatic send_word(input mlqs_pkg::kind_t kind,
                           input logic [mlqs_pkg::TAG_W-1:0] tag,
                           input mlqs_pkg::level_t level,
                           input logic [mlqs_pkg::PRIO_W-1:0] prio,
                           input logic [mlqs_pkg::BURST_W-1:0] burst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, burst, prio, level, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind != mlqs_pkg::KIND_NONE) words_sent++;
  endtask

  // A word of the given kind whose data fields are all random; for requests
  // and clears the block must ignore them.
  task automatic send_junk(input mlqs_pkg::kind_t kind);
    send_word(kind, mlqs_pkg::TAG_W'($urandom), mlqs_pkg::level_t'($urandom_range(0, 3)),
              mlqs_pkg::PRIO_W'($urandom), mlqs_pkg::BURST_W'($urandom));
  endtask

  // Drops valid, waits until every expected slice has arrived, then lets the
  // block settle in case its last word was a load or a clear.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_slices != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The quantum is only written while the block is idle.
  task automatic set_quantum(input logic [mlqs_pkg::QUANT_W-1:0] q);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_quantum = q;
  endtask

  // Loads one job with random content. Bursts are mostly short so that round
  // robin jobs take several slices; a few are zero or long. Priorities are
  // often drawn from a tiny range so that ties come up.
  task automatic load_random_job();
    mlqs_pkg::level_t             level;
    logic [mlqs_pkg::BURST_W-1:0] burst;
    logic [mlqs_pkg::PRIO_W-1:0]  prio;
    int unsigned                  q;
    level = ($urandom_range(0, 9) == 0) ? mlqs_pkg::LVL_IDLE
                                        : mlqs_pkg::level_t'($urandom_range(1, 3));
    case ($urandom_range(0, 9))
      0:       burst = '0;
      1:       burst = mlqs_pkg::BURST_W'($urandom);
      2:       burst = mlqs_pkg::BURST_W'($urandom_range(200, 1000));
      default: burst = mlqs_pkg::BURST_W'($urandom_range(1, 12));
    endcase
    prio = ($urandom_range(0, 1) == 0) ? mlqs_pkg::PRIO_W'($urandom_range(0, 3))
                                       : mlqs_pkg::PRIO_W'($urandom);
    q = (cur_quantum == '0) ? 1 : cur_quantum;
    if (burst != '0 && level != mlqs_pkg::LVL_IDLE)
      slices_left += (level == mlqs_pkg::LVL_RR) ? (burst + q - 1) / q : 1;
    send_word(mlqs_pkg::KIND_LOAD, mlqs_pkg::TAG_W'($urandom), level, prio, burst);
  endtask

  // One episode: usually a clear, a batch of loads (now and then enough to
  // overflow the table), then enough requests to finish the work and reach
  // the done result, mixed with late loads, ignored words and random kinds.
  task automatic run_episode();
    int unsigned jobs;
    int unsigned requests;
    int unsigned pick;
    if ($urandom_range(0, 3) != 0) begin
      send_junk(mlqs_pkg::KIND_CLEAR);
      slices_left = 0;
    end
    jobs = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
    repeat (jobs) load_random_job();
    requests = slices_left + $urandom_range(0, 2);
    if (requests > 40) requests = 40;
    while (requests != 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        load_random_job();
      end else if (pick == 1) begin
        send_junk(mlqs_pkg::KIND_NONE);
      end else if (pick == 2) begin
        send_junk(mlqs_pkg::kind_t'($urandom_range(0, 3)));
      end else begin
        send_junk(mlqs_pkg::KIND_NEXT);
        requests--;
        if (slices_left != 0) slices_left--;
      end
    end
  endtask

  initial begin
    logic [mlqs_pkg::QUANT_W-1:0] q;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    out_tready  <= 1'b0;
    rst_n       <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset quantum of 4. A request on an empty table
    // gives the done result, and an unused kind with every bit set is ignored.
    send_word(mlqs_pkg::KIND_NEXT, '0, mlqs_pkg::LVL_IDLE, '0, '0);
    send_word(mlqs_pkg::KIND_NONE, '1, mlqs_pkg::LVL_FCFS, '1, '1);
    send_word(mlqs_pkg::KIND_CLEAR, '1, mlqs_pkg::LVL_FCFS, '1, '1);
    // Two round robin jobs, a priority tie, a long priority job, a first come
    // job, and two jobs that must never be served: level zero and zero burst.
    send_word(mlqs_pkg::KIND_LOAD, 8'hFF, mlqs_pkg::LVL_RR,   8'h00, 16'd6);
    send_word(mlqs_pkg::KIND_LOAD, 8'h00, mlqs_pkg::LVL_RR,   8'hFF, 16'd3);
    send_word(mlqs_pkg::KIND_LOAD, 8'd1,  mlqs_pkg::LVL_PRIO, 8'hFF, 16'hFFFF);
    send_word(mlqs_pkg::KIND_LOAD, 8'd2,  mlqs_pkg::LVL_PRIO, 8'd5,  16'd10);
    send_word(mlqs_pkg::KIND_LOAD, 8'd3,  mlqs_pkg::LVL_PRIO, 8'd5,  16'd7);
    send_word(mlqs_pkg::KIND_LOAD, 8'd4,  mlqs_pkg::LVL_FCFS, 8'd9,  16'd1);
    send_word(mlqs_pkg::KIND_LOAD, 8'd5,  mlqs_pkg::LVL_IDLE, 8'd1,  16'd100);
    send_word(mlqs_pkg::KIND_LOAD, 8'd6,  mlqs_pkg::LVL_RR,   8'd2,  16'd0);
    repeat (4) send_word(mlqs_pkg::KIND_NEXT, '0, mlqs_pkg::LVL_IDLE, '0, '0);
    // A round robin job that arrives after priority service has begun must be
    // served before the rest of the priority work.
    send_word(mlqs_pkg::KIND_LOAD, 8'd7,  mlqs_pkg::LVL_RR,   8'd0,  16'd5);
    repeat (7) send_word(mlqs_pkg::KIND_NEXT, '1, mlqs_pkg::LVL_FCFS, '1, '1);
    // Repeated done result, then a clear that restarts the clock at zero.
    send_word(mlqs_pkg::KIND_CLEAR, '0, mlqs_pkg::LVL_IDLE, '0, '0);
    send_word(mlqs_pkg::KIND_NEXT, '0, mlqs_pkg::LVL_IDLE, '0, '0);

    // Random phases, each under its own quantum: the smallest, the largest,
    // zero (which acts as one), a random value, and the reset value again in a
    // final phase without any idling on either side.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       q = 8'd1;
        1:       q = 8'd255;
        2:       q = 8'd0;
        3:       q = mlqs_pkg::QUANT_W'($urandom_range(2, 254));
        default: q = mlqs_pkg::QUANT_RESET;
      endcase
      set_quantum(q);
      if (phase == 1) hold_request <= 1'b1;
      if (phase == PHASES - 1) quiet <= 1'b1;
      words_sent = 0;
      while (words_sent < PHASE_WORDS) run_episode();
    end

    drain();
    if (fail_count == 0 && open_slices == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
